FILE: rtl/qoi_pkg.sv
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared types, opcode constants and the color hash for the QOI RGB decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qoi_pkg;

    // decoded pixel, packed red-green-blue
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    // access request from the decoder to the color index memory
    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        pixel_t     wr_data;
        logic       rd_en;
        logic [5:0] rd_addr;
    } idx_req_t;

    // opcodes and tag field codes
    localparam logic [7:0] OP_LITERAL = 8'hFE;
    localparam logic [1:0] TAG_INDEX  = 2'b00;
    localparam logic [1:0] TAG_DIFF   = 2'b01;
    localparam logic [1:0] TAG_LUMA   = 2'b10;
    localparam logic [1:0] TAG_RUN    = 2'b11;

    // bias values of the diff and luma ops
    localparam logic [7:0] DIFF_BIAS  = 8'd2;
    localparam logic [7:0] LUMA_BIAS  = 8'd32;
    localparam logic [7:0] NIB_BIAS   = 8'd8;

    // index slot: (3r + 5g + 7b) mod 64, only the low six bits matter
    function automatic logic [5:0] slot_of(input pixel_t p);
        logic [5:0] s;
        s = p.r[5:0] * 6'd3 + p.g[5:0] * 6'd5 + p.b[5:0] * 6'd7;
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/qoi_byte_if.sv
// ----------------------------------------------------------------------------
// qoi_byte_if
// Valid/ready channel carrying one encoded payload byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface qoi_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/qoi_pixel_if.sv
// ----------------------------------------------------------------------------
// qoi_pixel_if
// Valid/ready channel carrying one decoded RGB pixel per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface qoi_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;

    modport source (output valid, output red, output green, output blue, output last,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input last,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/qoi_index_mem.sv
// ----------------------------------------------------------------------------
// qoi_index_mem
// 64-entry color index: one write and one read port, registered read data.
// Per-entry valid flops give the all-zero reset contents without a sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_index_mem (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  qoi_pkg::idx_req_t  req,
    output qoi_pkg::pixel_t    rd_data
);

    qoi_pkg::pixel_t mem [64];
    logic [63:0]     valid_reg;
    qoi_pkg::pixel_t rd_q_reg;
    logic            rd_hit_reg;

    // storage array and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    // written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // unwritten entries read as black
    assign rd_data = rd_hit_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/qoi_rgb_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// qoi_rgb_stream_decoder_unit
// Decodes the pixel payload of a three-channel QOI stream into RGB pixels.
//
// Channels: bytes (sink) takes one encoded byte per item; pixels (source)
// gives one decoded pixel per item, with last set on the final pixel that
// a byte produces. Bytes that only advance a multi-byte op give no pixel.
// Throughput: one byte per cycle for literal, diff and luma bytes while the
// output register is free. An index op holds the byte side in ST_IDX for
// the registered read of the color index memory. A run holds it in ST_RUN
// and gives one pixel per cycle while pixels.ready is high, each a copy of
// the previous-pixel register. A pixel appears in the output register the
// cycle after the byte that completes it, for an index op after ST_IDX.
// Reset: the previous pixel is black, the parser expects an opcode and all
// 64 index entries read as black; the block takes bytes right away.
// Stall: the output register holds its pixel while pixels.ready is low and
// bytes.ready drops until the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_rgb_stream_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    qoi_byte_if.sink         bytes,
    qoi_pixel_if.source      pixels
);

    // control states
    localparam logic [1:0] ST_IN  = 2'd0;
    localparam logic [1:0] ST_IDX = 2'd1;
    localparam logic [1:0] ST_RUN = 2'd2;

    // parse phases
    localparam logic [2:0] PH_OP    = 3'd0;
    localparam logic [2:0] PH_RED   = 3'd1;
    localparam logic [2:0] PH_GREEN = 3'd2;
    localparam logic [2:0] PH_BLUE  = 3'd3;
    localparam logic [2:0] PH_LUMA  = 3'd4;

    logic [1:0]        state_reg, state_next;
    logic [2:0]        phase_reg, phase_next;
    qoi_pkg::pixel_t   prev_reg, prev_next;
    logic [7:0]        pend_red_reg, pend_red_next;
    logic [7:0]        pend_green_reg, pend_green_next;
    logic [5:0]        pend_luma_reg, pend_luma_next;
    logic [5:0]        run_cnt_reg, run_cnt_next;
    logic              out_valid_reg, out_valid_next;
    qoi_pkg::pixel_t   out_pix_reg, out_pix_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              accept;
    logic [7:0]        in_b;
    qoi_pkg::idx_req_t idx_req;
    qoi_pkg::pixel_t   idx_rd_data;
    qoi_pkg::pixel_t   lit_pix;
    qoi_pkg::pixel_t   diff_pix;
    qoi_pkg::pixel_t   luma_pix;
    logic [7:0]        luma_dg;

    // color index memory
    qoi_index_mem u_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (idx_req),
        .rd_data (idx_rd_data)
    );

    // handshake
    assign in_b         = bytes.in_byte;
    assign out_free     = !out_valid_reg || pixels.ready;
    assign bytes.ready  = (state_reg == ST_IN) && out_free;
    assign accept       = bytes.valid && bytes.ready;

    // candidate pixels for the literal, diff and luma ops
    assign lit_pix  = '{r: pend_red_reg, g: pend_green_reg, b: in_b};
    assign diff_pix = '{r: prev_reg.r + {6'd0, in_b[5:4]} - qoi_pkg::DIFF_BIAS,
                        g: prev_reg.g + {6'd0, in_b[3:2]} - qoi_pkg::DIFF_BIAS,
                        b: prev_reg.b + {6'd0, in_b[1:0]} - qoi_pkg::DIFF_BIAS};
    assign luma_dg  = {2'd0, pend_luma_reg} - qoi_pkg::LUMA_BIAS;
    assign luma_pix = '{r: prev_reg.r + luma_dg + {4'd0, in_b[7:4]} - qoi_pkg::NIB_BIAS,
                        g: prev_reg.g + luma_dg,
                        b: prev_reg.b + luma_dg + {4'd0, in_b[3:0]} - qoi_pkg::NIB_BIAS};

    // parser and sequencer
    // an index write and a later index read never share an edge, and the array
    // is updated at the write edge, so a later read sees the new data
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        prev_next       = prev_reg;
        pend_red_next   = pend_red_reg;
        pend_green_next = pend_green_reg;
        pend_luma_next  = pend_luma_reg;
        run_cnt_next    = run_cnt_reg;
        out_pix_next    = out_pix_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !pixels.ready;
        idx_req         = '0;

        case (state_reg)
            ST_IN:
            begin
                if (accept)
                begin
                    case (phase_reg)
                        PH_RED:
                        begin
                            pend_red_next = in_b;
                            phase_next    = PH_GREEN;
                        end
                        PH_GREEN:
                        begin
                            pend_green_next = in_b;
                            phase_next      = PH_BLUE;
                        end
                        PH_BLUE:
                        begin
                            prev_next       = lit_pix;
                            out_pix_next    = lit_pix;
                            out_last_next   = 1'b1;
                            out_valid_next  = 1'b1;
                            idx_req.wr_en   = 1'b1;
                            idx_req.wr_addr = qoi_pkg::slot_of(lit_pix);
                            idx_req.wr_data = lit_pix;
                            phase_next      = PH_OP;
                        end
                        PH_LUMA:
                        begin
                            prev_next      = luma_pix;
                            out_pix_next   = luma_pix;
                            out_last_next  = 1'b1;
                            out_valid_next = 1'b1;
                            phase_next     = PH_OP;
                        end
                        default:
                        begin
                            // opcode byte; unused phase codes land here too
                            phase_next = PH_OP;
                            if (in_b == qoi_pkg::OP_LITERAL)
                            begin
                                phase_next = PH_RED;
                            end
                            else
                            begin
                                case (in_b[7:6])
                                    qoi_pkg::TAG_INDEX:
                                    begin
                                        idx_req.rd_en   = 1'b1;
                                        idx_req.rd_addr = in_b[5:0];
                                        state_next      = ST_IDX;
                                    end
                                    qoi_pkg::TAG_DIFF:
                                    begin
                                        prev_next      = diff_pix;
                                        out_pix_next   = diff_pix;
                                        out_last_next  = 1'b1;
                                        out_valid_next = 1'b1;
                                    end
                                    qoi_pkg::TAG_LUMA:
                                    begin
                                        pend_luma_next = in_b[5:0];
                                        phase_next     = PH_LUMA;
                                    end
                                    default:
                                    begin
                                        // run: first copy now, the rest from ST_RUN
                                        out_pix_next   = prev_reg;
                                        out_last_next  = (in_b[5:0] == 6'd0);
                                        out_valid_next = 1'b1;
                                        run_cnt_next   = in_b[5:0];
                                        if (in_b[5:0] != 6'd0)
                                        begin
                                            state_next = ST_RUN;
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            ST_IDX:
            begin
                // read data is ready; output register is empty here
                prev_next      = idx_rd_data;
                out_pix_next   = idx_rd_data;
                out_last_next  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IN;
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    out_pix_next   = prev_reg;
                    out_last_next  = (run_cnt_reg == 6'd1);
                    out_valid_next = 1'b1;
                    run_cnt_next   = run_cnt_reg - 6'd1;
                    if (run_cnt_reg == 6'd1)
                    begin
                        state_next = ST_IN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IN;
            end
        endcase
    end

    // control and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IN;
            phase_reg      <= PH_OP;
            prev_reg       <= '0;
            pend_red_reg   <= '0;
            pend_green_reg <= '0;
            pend_luma_reg  <= '0;
            run_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            prev_reg       <= prev_next;
            pend_red_reg   <= pend_red_next;
            pend_green_reg <= pend_green_next;
            pend_luma_reg  <= pend_luma_next;
            run_cnt_reg    <= run_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_pix_reg  <= out_pix_next;
        out_last_reg <= out_last_next;
    end

    assign pixels.valid = out_valid_reg;
    assign pixels.red   = out_pix_reg.r;
    assign pixels.green = out_pix_reg.g;
    assign pixels.blue  = out_pix_reg.b;
    assign pixels.last  = out_last_reg;

    // checks
    a_idx_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDX) |=> (state_reg == ST_IN) && out_valid_reg)
        else $error("index op did not deliver its pixel in one cycle");

    a_idx_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDX) |-> !out_valid_reg)
        else $error("output register busy while index data returns");

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (run_cnt_reg != 6'd0))
        else $error("run state with no copies left");

    a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IN) |-> !bytes.ready)
        else $error("byte taken while a run or index op is in progress");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg <= PH_LUMA))
        else $error("parse phase out of range");

endmodule

`default_nettype wire

FILE: dv/qoi_rgb_stream_decoder_unit_check.sv
// ----------------------------------------------------------------------------
// qoi_rgb_stream_decoder_unit_check
// Watches the byte and pixel channels of the QOI RGB decoder, decodes every
// accepted byte with its own copy of the parser state and compares each
// accepted pixel, field by field, with the oldest pixel still due.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_rgb_stream_decoder_unit_check (
    input  wire logic clk,
    input  wire logic rst_n,
    qoi_byte_if       bytes,
    qoi_pixel_if      pixels,
    output int        errors,
    output int        pixels_due
);

    // where the parser stands inside a multi-byte op
    typedef enum logic [2:0] {
        PH_OPCODE = 3'd0,
        PH_RED    = 3'd1,
        PH_GREEN  = 3'd2,
        PH_BLUE   = 3'd3,
        PH_LUMA   = 3'd4
    } parse_phase_t;

    typedef struct packed {
        qoi_pkg::pixel_t px;
        logic            last;
    } pixel_beat_t;

    qoi_pkg::pixel_t prev_px;
    qoi_pkg::pixel_t color_table [64];
    parse_phase_t    phase;
    logic [7:0]      held_red;
    logic [7:0]      held_green;
    logic [5:0]      held_luma;
    pixel_beat_t     due_q [$];
    pixel_beat_t     head;
    int              fail_count = 0;

    // hash slot of a pixel: (3r + 5g + 7b) mod 64
    function automatic logic [5:0] color_slot(input qoi_pkg::pixel_t p);
        logic [11:0] sum;
        sum = {4'b0, p.r} * 12'd3 + {4'b0, p.g} * 12'd5 + {4'b0, p.b} * 12'd7;
        return sum[5:0];
    endfunction

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        fail_count++;
        $display("[%0t] pixel mismatch on %s: got %02h, expected %02h",
                 $time, what, got, want);
    endtask

    // decode one byte and queue the pixels it completes
    task automatic decode_byte(input logic [7:0] value);
        logic [7:0] dg;
        case (phase)
            PH_RED:
            begin
                held_red = value;
                phase    = PH_GREEN;
            end
            PH_GREEN:
            begin
                held_green = value;
                phase      = PH_BLUE;
            end
            PH_BLUE:
            begin
                prev_px = {held_red, held_green, value};
                color_table[color_slot(prev_px)] = prev_px;
                phase = PH_OPCODE;
                due_q.push_back({prev_px, 1'b1});
            end
            PH_LUMA:
            begin
                dg = {2'b00, held_luma} - qoi_pkg::LUMA_BIAS;
                prev_px.r = prev_px.r + dg + {4'b0, value[7:4]} - qoi_pkg::NIB_BIAS;
                prev_px.g = prev_px.g + dg;
                prev_px.b = prev_px.b + dg + {4'b0, value[3:0]} - qoi_pkg::NIB_BIAS;
                phase = PH_OPCODE;
                due_q.push_back({prev_px, 1'b1});
            end
            default:
            begin
                // byte read as an opcode
                phase = PH_OPCODE;
                if (value == qoi_pkg::OP_LITERAL)
                begin
                    phase = PH_RED;
                end
                else
                begin
                    case (value[7:6])
                        qoi_pkg::TAG_INDEX:
                        begin
                            prev_px = color_table[value[5:0]];
                            due_q.push_back({prev_px, 1'b1});
                        end
                        qoi_pkg::TAG_DIFF:
                        begin
                            prev_px.r = prev_px.r + {6'b0, value[5:4]} - qoi_pkg::DIFF_BIAS;
                            prev_px.g = prev_px.g + {6'b0, value[3:2]} - qoi_pkg::DIFF_BIAS;
                            prev_px.b = prev_px.b + {6'b0, value[1:0]} - qoi_pkg::DIFF_BIAS;
                            due_q.push_back({prev_px, 1'b1});
                        end
                        qoi_pkg::TAG_LUMA:
                        begin
                            held_luma = value[5:0];
                            phase     = PH_LUMA;
                        end
                        default:
                        begin
                            // run of data + 1 copies, 0xFF gives 64
                            for (int k = 0; k <= value[5:0]; k++)
                                due_q.push_back({prev_px, 1'(k == value[5:0])});
                        end
                    endcase
                end
            end
        endcase
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_px = '0;
            foreach (color_table[i])
                color_table[i] = '0;
            phase      = PH_OPCODE;
            held_red   = '0;
            held_green = '0;
            held_luma  = '0;
            due_q.delete();
            pixels_due <= 0;
        end
        else
        begin
            if (bytes.valid && bytes.ready)
                decode_byte(bytes.in_byte);
            if (pixels.valid && pixels.ready)
            begin
                if (due_q.size() == 0)
                begin
                    report("red, no pixel due", pixels.red, 8'h00);
                end
                else
                begin
                    head = due_q.pop_front();
                    if (pixels.red !== head.px.r)
                        report("red", pixels.red, head.px.r);
                    if (pixels.green !== head.px.g)
                        report("green", pixels.green, head.px.g);
                    if (pixels.blue !== head.px.b)
                        report("blue", pixels.blue, head.px.b);
                    if (pixels.last !== head.last)
                        report("last", {7'b0, pixels.last}, {7'b0, head.last});
                end
            end
            pixels_due <= due_q.size();
        end
        errors <= fail_count;
    end

endmodule

`default_nettype wire

FILE: dv/qoi_rgb_stream_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// qoi_rgb_stream_decoder_unit_test
// Feeds the QOI RGB decoder a directed byte stream covering every op and its
// edge values, then random well-formed op sequences mixed with stray bytes,
// under random idling on both channels, a long output hold-off and a full
// drain. The checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_rgb_stream_decoder_unit_test;

    localparam int LONG_HOLD = 200;
    localparam int TAIL      = 8;

    logic clk;
    logic rst_n;
    int   err_total;
    int   pixels_due;
    int   bytes_sent    = 0;
    bit   tx_idle       = 1'b1;
    bit   rx_idle       = 1'b1;
    bit   long_hold_req = 1'b0;

    qoi_byte_if  byte_ch ();
    qoi_pixel_if pix_ch ();

    qoi_rgb_stream_decoder_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .pixels (pix_ch)
    );

    qoi_rgb_stream_decoder_unit_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (byte_ch),
        .pixels     (pix_ch),
        .errors     (err_total),
        .pixels_due (pixels_due)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // offer one byte, with an optional idle burst first, and wait for it
    task automatic push_byte(input logic [7:0] value);
        if (tx_idle && $urandom_range(0, 7) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= value;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    // stop offering and wait until every due pixel has come out
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pixels_due != 0) @(posedge clk);
    endtask

    // one random op, well formed most of the time
    task automatic send_random_op();
        int         pick;
        logic [5:0] data;
        pick = $urandom_range(0, 99);
        data = 6'($urandom_range(0, 63));
        if (pick < 10)
        begin
            push_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 28)
        begin
            push_byte(qoi_pkg::OP_LITERAL);
            repeat (3) push_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 44)
            push_byte({qoi_pkg::TAG_INDEX, data});
        else if (pick < 60)
            push_byte({qoi_pkg::TAG_DIFF, data});
        else if (pick < 78)
        begin
            push_byte({qoi_pkg::TAG_LUMA, data});
            push_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 94)
            push_byte({qoi_pkg::TAG_RUN, 6'($urandom_range(0, 7))});
        else if (pick < 97)
            push_byte({qoi_pkg::TAG_RUN, 6'($urandom_range(8, 61))});
        else
            push_byte({qoi_pkg::TAG_RUN, 6'h3F});
    endtask

    task automatic send_ops(input int count);
        int goal;
        goal = bytes_sent + count;
        while (bytes_sent < goal) send_random_op();
    endtask

    // pixel receiver with random stalls and one long hold-off on request
    initial
    begin
        pix_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                pix_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (rx_idle && $urandom_range(0, 7) == 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                pix_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n           <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // index read of a never written slot, still black
        push_byte({qoi_pkg::TAG_INDEX, 6'd0});
        // literal with extreme channels
        push_byte(qoi_pkg::OP_LITERAL);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h80);
        // literal opcode byte taken as data in every channel
        push_byte(qoi_pkg::OP_LITERAL);
        push_byte(qoi_pkg::OP_LITERAL);
        push_byte(qoi_pkg::OP_LITERAL);
        push_byte(qoi_pkg::OP_LITERAL);
        // index at the top slot
        push_byte({qoi_pkg::TAG_INDEX, 6'h3F});
        // diff extremes
        push_byte({qoi_pkg::TAG_DIFF, 6'h00});
        push_byte({qoi_pkg::TAG_DIFF, 6'h3F});
        // luma extremes and literal opcode as the second byte
        push_byte({qoi_pkg::TAG_LUMA, 6'h00});
        push_byte(8'h00);
        push_byte({qoi_pkg::TAG_LUMA, 6'h3F});
        push_byte(8'hFF);
        push_byte({qoi_pkg::TAG_LUMA, 6'h15});
        push_byte(qoi_pkg::OP_LITERAL);
        // shortest run and the 64-pixel run
        push_byte({qoi_pkg::TAG_RUN, 6'h00});
        push_byte({qoi_pkg::TAG_RUN, 6'h3F});
        wait_drained();

        // random ops with idling on both sides
        send_ops(80);
        // receiver holds off while the sender keeps offering
        long_hold_req = 1'b1;
        send_ops(30);
        send_ops(50);
        wait_drained();

        // closing stretch at full rate
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_ops(40);
        wait_drained();
        repeat (TAIL) @(posedge clk);

        if (err_total == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/qoi_pkg.sv
rtl/qoi_byte_if.sv
rtl/qoi_pixel_if.sv
rtl/qoi_index_mem.sv
rtl/qoi_rgb_stream_decoder_unit.sv
dv/qoi_rgb_stream_decoder_unit_check.sv
dv/qoi_rgb_stream_decoder_unit_test.sv
